FILE: hdl/qabm_pkg.sv
// ---------------------------------------------------------------------------
// qabm_pkg
// Shared types, delimiter codes and lookup functions for the quote-aware
// bracket matcher.
// ---------------------------------------------------------------------------
`default_nettype none

package qabm_pkg;

    // default stack depth
    localparam int STACK_DEPTH_DEF = 64;

    // stack entry width
    localparam int CODE_W = 4;

    // delimiter codes, zero means not a delimiter
    localparam logic [CODE_W-1:0] D_NONE  = 4'd0;
    localparam logic [CODE_W-1:0] D_PAR_O = 4'd1;
    localparam logic [CODE_W-1:0] D_PAR_C = 4'd2;
    localparam logic [CODE_W-1:0] D_SQB_O = 4'd3;
    localparam logic [CODE_W-1:0] D_SQB_C = 4'd4;
    localparam logic [CODE_W-1:0] D_CUR_O = 4'd5;
    localparam logic [CODE_W-1:0] D_CUR_C = 4'd6;
    localparam logic [CODE_W-1:0] D_SQUOT = 4'd7;
    localparam logic [CODE_W-1:0] D_DQUOT = 4'd8;
    localparam logic [CODE_W-1:0] D_BTICK = 4'd9;

    // ASCII characters of interest
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LSQB   = 8'h5B;
    localparam logic [7:0] CH_RSQB   = 8'h5D;
    localparam logic [7:0] CH_LCUR   = 8'h7B;
    localparam logic [7:0] CH_RCUR   = 8'h7D;
    localparam logic [7:0] CH_SQUOT  = 8'h27;
    localparam logic [7:0] CH_DQUOT  = 8'h22;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // one request on the byte channel
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_line;
    } qabm_in_t;

    // one request on the result channel
    typedef struct packed {
        logic [7:0] missing_delim;
        logic       stack_overflow;
    } qabm_out_t;

    // bracket or backtick code of a byte seen outside quotes
    function automatic logic [CODE_W-1:0] bracket_code(input logic [7:0] ch);
        logic [CODE_W-1:0] code;
        case (ch)
            CH_BTICK:  code = D_BTICK;
            CH_LSQB:   code = D_SQB_O;
            CH_RSQB:   code = D_SQB_C;
            CH_LCUR:   code = D_CUR_O;
            CH_RCUR:   code = D_CUR_C;
            CH_LPAREN: code = D_PAR_O;
            CH_RPAREN: code = D_PAR_C;
            default:   code = D_NONE;
        endcase
        return code;
    endfunction

    // opener that a code closes, D_NONE if it closes nothing
    function automatic logic [CODE_W-1:0] closes(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] want;
        case (code)
            D_PAR_C: want = D_PAR_O;
            D_SQB_C: want = D_SQB_O;
            D_CUR_C: want = D_CUR_O;
            D_SQUOT: want = D_SQUOT;
            D_DQUOT: want = D_DQUOT;
            D_BTICK: want = D_BTICK;
            default: want = D_NONE;
        endcase
        return want;
    endfunction

    // ASCII character of a stack code
    function automatic logic [7:0] code_to_ascii(input logic [CODE_W-1:0] code);
        logic [7:0] ch;
        case (code)
            D_PAR_O: ch = CH_LPAREN;
            D_PAR_C: ch = CH_RPAREN;
            D_SQB_O: ch = CH_LSQB;
            D_SQB_C: ch = CH_RSQB;
            D_CUR_O: ch = CH_LCUR;
            D_CUR_C: ch = CH_RCUR;
            D_SQUOT: ch = CH_SQUOT;
            D_DQUOT: ch = CH_DQUOT;
            D_BTICK: ch = CH_BTICK;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/qabm_ram.sv
// ---------------------------------------------------------------------------
// qabm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module qabm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: hdl/quote_aware_bracket_matcher.sv
// ---------------------------------------------------------------------------
// quote_aware_bracket_matcher
// Checks brackets, quotes and backticks of a command line, one byte per
// request, and reports the unmatched top delimiter at the end of each line.
// ---------------------------------------------------------------------------
//
//  channel   handshake            payload     carries
//  src       src_valid/src_stall  src_data    one byte plus end-of-line mark
//  res       res_valid/res_stall  res_data    missing delimiter, overflow flag
//
//  One byte is taken every cycle unless src_stall is high; the delimiter
//  stack sits in a RAM with one write and one registered read port, a
//  bypass covers a read of the entry written in the cycle before.
//  After the last byte of its line, a result passes the stack read stage
//  and then the two-entry output queue.
//  src_stall rises only while two results are queued or in flight and the
//  result side stalls.
//  Reset clears all control state at once; the stack RAM needs no clearing.
// ---------------------------------------------------------------------------
`default_nettype none

module quote_aware_bracket_matcher
    import qabm_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      src_valid,
    output logic           src_stall,
    input  wire qabm_in_t  src_data,
    output logic           res_valid,
    input  wire logic      res_stall,
    output qabm_out_t      res_data
);

    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    // line state
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               dq_reg, dq_next;
    logic               sq_reg, sq_next;
    logic               bs_reg, bs_next;
    logic               ovf_reg, ovf_next;

    // stack top bypass
    logic               byp_sel_reg, byp_sel_next;
    logic [CODE_W-1:0]  byp_data_reg, byp_data_next;

    // end-of-line stage
    logic               fin_valid_reg, fin_valid_next;
    logic               fin_full_reg, fin_full_next;
    logic               fin_ovf_reg, fin_ovf_next;

    // output queue
    qabm_out_t          q0_reg, q0_next;
    qabm_out_t          q1_reg, q1_next;
    logic [1:0]         cnt_reg, cnt_next;

    // datapath
    logic               src_fire;
    logic               res_fire;
    logic               escaped;
    logic [CODE_W-1:0]  code;
    logic [CODE_W-1:0]  want;
    logic [CODE_W-1:0]  top;
    logic               do_pop;
    logic               do_push;
    logic               do_drop;
    logic [DEPTH_W-1:0] depth_after;
    logic [DEPTH_W-1:0] depth_m1;
    logic               ovf_after;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [CODE_W-1:0]  rd_data;
    qabm_out_t          fin_res;

    assign src_fire = src_valid && !src_stall;
    assign res_fire = res_valid && !res_stall;

    // room for a result from every byte in flight, unless one leaves now
    assign src_stall = res_stall
                       && ((cnt_reg == 2'd2) || ((cnt_reg == 2'd1) && fin_valid_reg));

    // stack top from RAM or from last cycle's write
    assign top = byp_sel_reg ? byp_data_reg : rd_data;

    // byte decode
    always_comb
    begin
        escaped = bs_reg;
        code    = D_NONE;
        dq_next = dq_reg;
        sq_next = sq_reg;
        bs_next = bs_reg;
        if (src_fire)
        begin
            bs_next = (src_data.char_in == CH_BSLASH) ? !bs_reg : 1'b0;
            if (!escaped)
            begin
                if (src_data.char_in == CH_DQUOT && !sq_reg)
                begin
                    code    = D_DQUOT;
                    dq_next = !dq_reg;
                end
                else if (src_data.char_in == CH_SQUOT && !dq_reg)
                begin
                    code    = D_SQUOT;
                    sq_next = !sq_reg;
                end
                else if (!dq_reg && !sq_reg)
                begin
                    code = bracket_code(src_data.char_in);
                end
            end
            if (src_data.end_of_line)
            begin
                dq_next = 1'b0;
                sq_next = 1'b0;
                bs_next = 1'b0;
            end
        end
    end

    // stack update
    always_comb
    begin
        want    = closes(code);
        do_pop  = (code != D_NONE) && (depth_reg != '0) && (want != D_NONE)
                  && (top == want);
        do_drop = (code != D_NONE) && !do_pop
                  && (depth_reg == DEPTH_W'(STACK_DEPTH));
        do_push = (code != D_NONE) && !do_pop && !do_drop;
        depth_after = depth_reg;
        if (do_pop)
        begin
            depth_after = depth_reg - DEPTH_W'(1);
        end
        else if (do_push)
        begin
            depth_after = depth_reg + DEPTH_W'(1);
        end
        ovf_after  = ovf_reg || do_drop;
        depth_m1   = depth_after - DEPTH_W'(1);
        wr_addr    = depth_reg[ADDR_W-1:0];
        rd_addr    = depth_m1[ADDR_W-1:0];
        depth_next = (src_fire && src_data.end_of_line) ? '0 : depth_after;
        ovf_next   = (src_fire && src_data.end_of_line) ? 1'b0 : ovf_after;
        byp_sel_next  = do_push && (wr_addr == rd_addr);
        byp_data_next = code;
    end

    // hand the line's end to the read stage
    always_comb
    begin
        fin_valid_next = src_fire && src_data.end_of_line;
        fin_full_next  = depth_after != '0;
        fin_ovf_next   = ovf_after;
    end

    // result from the stack top, read in the cycle after the line's end
    always_comb
    begin
        fin_res.missing_delim  = fin_full_reg ? code_to_ascii(top) : 8'h00;
        fin_res.stack_overflow = fin_ovf_reg;
    end

    // two-entry output queue
    always_comb
    begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        case ({fin_valid_reg, res_fire})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                begin
                    q0_next = fin_res;
                end
                else
                begin
                    q1_next = fin_res;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                q0_next  = q1_reg;
                cnt_next = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    q0_next = fin_res;
                end
                else
                begin
                    q0_next = q1_reg;
                    q1_next = fin_res;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    assign res_valid = cnt_reg != 2'd0;
    assign res_data  = q0_reg;

    // delimiter stack
    qabm_ram #(
        .WIDTH (CODE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (do_push),
        .wr_addr (wr_addr),
        .wr_data (code),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            dq_reg        <= 1'b0;
            sq_reg        <= 1'b0;
            bs_reg        <= 1'b0;
            ovf_reg       <= 1'b0;
            byp_sel_reg   <= 1'b0;
            fin_valid_reg <= 1'b0;
            cnt_reg       <= 2'd0;
        end
        else
        begin
            depth_reg     <= depth_next;
            dq_reg        <= dq_next;
            sq_reg        <= sq_next;
            bs_reg        <= bs_next;
            ovf_reg       <= ovf_next;
            byp_sel_reg   <= byp_sel_next;
            fin_valid_reg <= fin_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byp_data_reg <= byp_data_next;
        fin_full_reg <= fin_full_next;
        fin_ovf_reg  <= fin_ovf_next;
        q0_reg       <= q0_next;
        q1_reg       <= q1_next;
    end

    // stack never grows past its size
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond its size");

    // end of line clears the line state
    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (src_fire && src_data.end_of_line) |=>
            (depth_reg == '0) && !ovf_reg && !dq_reg && !sq_reg && !bs_reg
            && fin_valid_reg)
        else $error("line state not cleared after last byte");

    // queue never overruns
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !((cnt_reg == 2'd2) && fin_valid_reg))
        else $error("result arrived at a full queue");

    // a dropped push only happens on a full stack and is remembered
    a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (do_drop && !src_data.end_of_line) |=> ovf_reg)
        else $error("dropped push not flagged");

endmodule

`default_nettype wire
